>>> src/str_pkg.sv
`default_nettype none
package str_pkg;

    localparam int ENTRIES_DEF      = 8;
    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int SEG_BYTES_DEF    = 64;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_FULL     = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_BAD_IDX  = 3'd4,
        ST_TOO_LONG = 3'd5
    } t_status;

    typedef struct packed {
        logic        func;
        logic [31:0] link_id;
        logic [7:0]  trans_num;
        logic [15:0] declared_len;
        logic [5:0]  last_seg_index;
        logic [5:0]  seg_index;
        logic [7:0]  byte_value;
        logic        byte_last;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_link_id;
        logic [7:0]  out_trans_num;
        logic [15:0] out_total;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_WRITE
    } t_state;

endpackage
`default_nettype wire

>>> src/segmented_transaction_reassembly_core.sv
`default_nettype none
// A request runs through search, decide and write steps, and a new one is accepted
// only in idle; the table search compares one entry per cycle in a shared comparator.
// A result still held by the receiver stalls the next request in its write step until
// the result is taken.
// Reset: synchronous active low; clears slot valid bits, byte position, control.
module segmented_transaction_reassembly_core
    import str_pkg::*;
#(
    parameter int ENTRIES      = ENTRIES_DEF,
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int SEG_BYTES    = SEG_BYTES_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  wire  i_ready,
    output t_out o_data
);
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int BW = (SEG_BYTES > 1) ? $clog2(SEG_BYTES) : 1;
    localparam int LW = EW + SW;

    t_state r_state, n_state;
    t_in    r_req;
    t_out   r_out;

    logic [ENTRIES-1:0]       r_ev;
    logic [ENTRIES-1:0][39:0] r_key;
    logic [15:0]              r_elen  [ENTRIES];
    logic [15:0]              r_etot  [ENTRIES];
    logic [5:0]               r_elast [ENTRIES];
    logic [6:0]               r_pos;

    logic [7:0] r_bytes [2**(LW+BW)];

    logic          s_start, s_done, s_hit, s_free;
    logic [EW-1:0] s_hit_idx, s_free_idx;

    str_search #(.ENTRIES(ENTRIES)) u_search (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(s_start),
        .i_valid(r_ev), .i_keys(r_key), .i_key({r_req.link_id, r_req.trans_num}),
        .o_done(s_done), .o_hit(s_hit), .o_hit_idx(s_hit_idx),
        .o_free(s_free), .o_free_idx(s_free_idx)
    );

    // decision registers
    logic [EW-1:0] r_e;
    logic          r_err;
    logic [2:0]    r_est;
    logic [15:0]   r_etotv;
    logic          r_init;
    logic [SW-1:0] r_s;

    logic [EW-1:0] hit_e, free_e;
    assign hit_e  = s_hit_idx;
    assign free_e = s_free_idx;

    logic c_start, c_bad_last, c_full, c_unknown;
    assign c_start    = !r_req.func && (r_pos == 7'd0);
    assign c_bad_last = c_start && (32'(r_req.last_seg_index) >= MAX_SEGMENTS);
    assign c_full     = c_start && !c_bad_last && !s_hit && !s_free;
    assign c_unknown  = !c_start && !s_hit;

    logic [6:0]  len;
    logic [16:0] sum;
    logic [15:0] sat;
    assign len = r_pos + 7'd1;
    assign sum = {1'b0, r_etot[r_e]} + 17'(len);
    assign sat = sum[16] ? 16'hFFFF : sum[15:0];

    logic [5:0] sidx;
    assign sidx = r_req.func ? r_req.seg_index : 6'd0;

    // write step proceeds once the previous result has been taken
    logic w_go, w_emit;
    assign w_go   = (r_state == S_WRITE) && (!o_valid || i_ready);
    assign w_emit = w_go && (r_err || r_req.byte_last);

    assign o_ready = (r_state == S_IDLE);
    assign o_data  = r_out;
    assign s_start = (r_state == S_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_SEARCH;
            S_SEARCH: if (s_done) n_state = S_DECIDE;
            S_DECIDE: n_state = S_WRITE;
            S_WRITE:  if (!o_valid || i_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_go && !r_err) begin
            r_bytes[{r_e, r_s, BW'(r_pos)}] <= r_req.byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev    <= '0;
            r_pos   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (w_emit) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid) r_req <= i_data;
                S_SEARCH: if (s_done) begin
                    r_err   <= c_bad_last || c_full || c_unknown;
                    r_est   <= c_bad_last ? ST_BAD_IDX : (c_full ? ST_FULL : ST_UNKNOWN);
                    r_init  <= c_start && !c_bad_last && !c_full;
                    r_e     <= s_hit ? hit_e : free_e;
                    r_etotv <= s_hit ? r_etot[hit_e] : 16'd0;
                end
                S_DECIDE: begin
                    if (r_init) begin
                        r_ev[r_e]    <= 1'b1;
                        r_key[r_e]   <= {r_req.link_id, r_req.trans_num};
                        r_elen[r_e]  <= r_req.declared_len;
                        r_elast[r_e] <= r_req.last_seg_index;
                        r_etot[r_e]  <= 16'd0;
                        r_etotv      <= 16'd0;
                    end
                    r_s <= SW'(sidx);
                    if (!r_err) begin
                        if (32'(sidx) >= MAX_SEGMENTS ||
                            sidx > (r_init ? r_req.last_seg_index : r_elast[r_e])) begin
                            r_err <= 1'b1; r_est <= ST_BAD_IDX;
                        end else if (32'(r_pos) >= SEG_BYTES) begin
                            r_err <= 1'b1; r_est <= ST_TOO_LONG;
                        end
                    end
                end
                S_WRITE: if (!o_valid || i_ready) begin
                    r_out.out_link_id   <= r_req.link_id;
                    r_out.out_trans_num <= r_req.trans_num;
                    if (r_err) begin
                        r_pos <= '0;
                        r_out.status    <= r_est;
                        r_out.out_total <= r_etotv;
                    end else begin
                        if (!r_req.byte_last) begin
                            r_pos <= len;
                        end else begin
                            r_pos <= '0;
                            if (!r_req.func) begin
                                r_etot[r_e]     <= 16'(len);
                                r_out.status    <= ST_STORED;
                                r_out.out_total <= 16'(len);
                            end else begin
                                r_etot[r_e]     <= sat;
                                r_out.out_total <= sat;
                                if (sat == r_elen[r_e]) begin
                                    r_ev[r_e]    <= 1'b0;
                                    r_out.status <= ST_COMPLETE;
                                end else begin
                                    r_out.status <= ST_STORED;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> src/str_search.sv
`default_nettype none
// Sequential table search: compares one entry per cycle with the shared comparator.
module str_search
    import str_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire  [ENTRIES-1:0]        i_valid,
    input  wire  [ENTRIES-1:0][39:0]  i_keys,
    input  wire  [39:0]               i_key,
    output logic                      o_done,
    output logic                      o_hit,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_hit_idx,
    output logic                      o_free,
    output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] o_free_idx
);
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic          r_busy;
    logic [EW-1:0] r_idx;
    logic [EW-1:0] n_idx;
    logic [EW-1:0] r_last;
    logic          cmp_eq;

    assign r_last = EW'(ENTRIES - 1);
    assign n_idx  = r_idx + EW'(1);
    assign cmp_eq = i_valid[r_idx] && (i_keys[r_idx] == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy     <= 1'b1;
                r_idx      <= '0;
                o_hit      <= 1'b0;
                o_free     <= 1'b0;
                o_hit_idx  <= '0;
                o_free_idx <= '0;
            end else if (r_busy) begin
                if (cmp_eq && !o_hit) begin
                    o_hit     <= 1'b1;
                    o_hit_idx <= r_idx;
                end
                if (!i_valid[r_idx] && !o_free) begin
                    o_free     <= 1'b1;
                    o_free_idx <= r_idx;
                end
                if (r_idx == r_last) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_idx <= n_idx;
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/segmented_transaction_reassembly_core_tb.sv
`timescale 1ns / 1ps
module segmented_transaction_reassembly_core_tb
    import str_pkg::*;
();

    localparam int N_ENT  = ENTRIES_DEF;
    localparam int N_SEG  = MAX_SEGMENTS_DEF;
    localparam int N_BYTE = SEG_BYTES_DEF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_STALL = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    segmented_transaction_reassembly_core u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always #6 i_clk = ~i_clk;

    // predictor state of the reassembly table
    logic        slot_valid [N_ENT];
    logic [31:0] slot_link  [N_ENT];
    logic [7:0]  slot_trans [N_ENT];
    logic [15:0] slot_length[N_ENT];
    logic [15:0] slot_total [N_ENT];
    logic [5:0]  slot_last  [N_ENT];
    int          pred_pos;

    t_out expected_q[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    bit   rx_long = 1'b0;

    function automatic t_out make_result(t_status st, t_in r, logic [15:0] tot);
        t_out o;
        o.status        = st;
        o.out_link_id   = r.link_id;
        o.out_trans_num = r.trans_num;
        o.out_total     = tot;
        return o;
    endfunction

    task automatic predict_reassembly(input t_in r);
        int e;
        int s;
        int len;
        int t;
        e = -1;
        for (int i = 0; i < N_ENT; i++)
            if (e < 0 && slot_valid[i] && slot_link[i] == r.link_id
                && slot_trans[i] == r.trans_num)
                e = i;
        if (!r.func && pred_pos == 0) begin
            if (int'(r.last_seg_index) >= N_SEG) begin
                pred_pos = 0;
                expected_q.push_back(make_result(ST_BAD_IDX, r,
                    e >= 0 ? slot_total[e] : 16'd0));
                return;
            end
            if (e < 0) begin
                for (int i = 0; i < N_ENT; i++)
                    if (e < 0 && !slot_valid[i]) e = i;
                if (e < 0) begin
                    pred_pos = 0;
                    expected_q.push_back(make_result(ST_FULL, r, 16'd0));
                    return;
                end
            end
            slot_valid[e]  = 1'b1;
            slot_link[e]   = r.link_id;
            slot_trans[e]  = r.trans_num;
            slot_length[e] = r.declared_len;
            slot_last[e]   = r.last_seg_index;
            slot_total[e]  = '0;
        end
        if (e < 0) begin
            pred_pos = 0;
            expected_q.push_back(make_result(ST_UNKNOWN, r, 16'd0));
            return;
        end
        s = r.func ? int'(r.seg_index) : 0;
        if (s >= N_SEG || s > int'(slot_last[e])) begin
            pred_pos = 0;
            expected_q.push_back(make_result(ST_BAD_IDX, r, slot_total[e]));
            return;
        end
        if (pred_pos >= N_BYTE) begin
            pred_pos = 0;
            expected_q.push_back(make_result(ST_TOO_LONG, r, slot_total[e]));
            return;
        end
        len = pred_pos + 1;
        if (!r.byte_last) begin
            pred_pos = len & 8'h7f;
            return;
        end
        pred_pos = 0;
        if (!r.func) begin
            slot_total[e] = len[15:0];
            expected_q.push_back(make_result(ST_STORED, r, slot_total[e]));
            return;
        end
        t = int'(slot_total[e]) + len;
        if (t > 65535) t = 65535;
        slot_total[e] = t[15:0];
        if (slot_total[e] == slot_length[e]) begin
            slot_valid[e] = 1'b0;
            expected_q.push_back(make_result(ST_COMPLETE, r, slot_total[e]));
        end else begin
            expected_q.push_back(make_result(ST_STORED, r, slot_total[e]));
        end
    endtask

    // drive one request, then idle a random number of cycles
    task automatic send_byte(input t_in r);
        int n_wait;
        i_data  <= r;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_reassembly(r);
        @(negedge i_clk);
        n_wait = $urandom_range(0, 6);
        if (n_wait > 0) begin
            i_valid <= 1'b0;
            repeat (n_wait) @(negedge i_clk);
        end
    endtask

    function automatic t_in make_byte(bit fn, logic [31:0] lk, logic [7:0] tn,
                                      logic [15:0] tl, logic [5:0] ls,
                                      logic [5:0] si, bit bl);
        t_in r;
        r.func           = fn;
        r.link_id        = lk;
        r.trans_num      = tn;
        r.declared_len   = tl;
        r.last_seg_index = ls;
        r.seg_index      = si;
        r.byte_value     = 8'($urandom);
        r.byte_last      = bl;
        return r;
    endfunction

    // send one whole segment of n bytes
    task automatic send_segment(bit fn, logic [31:0] lk, logic [7:0] tn,
                                logic [15:0] tl, logic [5:0] ls,
                                logic [5:0] si, int n);
        for (int k = 0; k < n; k++)
            send_byte(make_byte(fn, lk, tn, tl, ls, si, k == n - 1));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // receiver: random wait before each result, long hold when rx_long is set
    initial begin
        int wait_n;
        @(negedge i_clk);
        forever begin
            wait_n = $urandom_range(0, 6);
            if (wait_n > 0 || rx_long) begin
                i_ready <= 1'b0;
                repeat (wait_n) @(negedge i_clk);
                if (rx_long) begin
                    repeat (LONG_STALL) @(negedge i_clk);
                    rx_long = 1'b0;
                end
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out exp_r;
        if (o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result exp=none act=%h", $time, o_data);
                error_count++;
            end else begin
                exp_r = expected_q.pop_front();
                if (o_data.status !== exp_r.status)
                    $display("%0t: status exp=%0d act=%0d", $time,
                             exp_r.status, o_data.status);
                if (o_data.out_link_id !== exp_r.out_link_id)
                    $display("%0t: link exp=%h act=%h", $time,
                             exp_r.out_link_id, o_data.out_link_id);
                if (o_data.out_trans_num !== exp_r.out_trans_num)
                    $display("%0t: trans exp=%h act=%h", $time,
                             exp_r.out_trans_num, o_data.out_trans_num);
                if (o_data.out_total !== exp_r.out_total)
                    $display("%0t: total exp=%0d act=%0d", $time,
                             exp_r.out_total, o_data.out_total);
                if (o_data !== exp_r) error_count++;
            end
        end
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("segmented_transaction_reassembly_core verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        // start with extreme ids and a full-size segment, then completion
        send_segment(1'b0, 32'hFFFF_FFFF, 8'hFF, 16'd65, 6'd1, 6'd63, N_BYTE);
        send_segment(1'b1, 32'hFFFF_FFFF, 8'hFF, 16'd0, 6'd0, 6'd1, 1);
        // unknown continuation, bad index, too long
        send_segment(1'b1, 32'h0, 8'h0, 16'hFFFF, 6'd63, 6'd0, 1);
        send_segment(1'b0, 32'h0, 8'h0, 16'hFFFF, 6'd0, 6'd0, 1);
        send_segment(1'b1, 32'h0, 8'h0, 16'd0, 6'd0, 6'd5, 1);
        send_segment(1'b0, 32'h1, 8'h1, 16'd3, 6'd2, 6'd0, N_BYTE + 1);
        // start segment that is too long errors on byte 65
        wait_drained();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < N_ENT + 2; i++)
            send_segment(1'b0, 32'h100 + i, 8'(i), 16'd50, 6'd3, 6'd0, 1);
        // duplicate index on continuation, then saturation is not reachable cheaply
        send_segment(1'b1, 32'h100, 8'd0, 16'd0, 6'd0, 6'd2, 2);
        send_segment(1'b1, 32'h100, 8'd0, 16'd0, 6'd0, 6'd2, 2);
        wait_drained();
        // drain table by restarting each and completing
        for (int i = 0; i < N_ENT + 2; i++) begin
            send_segment(1'b0, 32'h100 + i, 8'(i), 16'd2, 6'd1, 6'd0, 1);
            send_segment(1'b1, 32'h100 + i, 8'(i), 16'd0, 6'd0, 6'd1, 1);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        rx_long = 1'b1;
        for (int i = 0; i < 30; i++)
            send_segment(1'b0, 32'h2000, 8'd7, 16'd9, 6'd4, 6'd0, 1);
        wait_drained();
    endtask

    task automatic test_random(int n_items);
        int sent;
        logic [31:0] lk;
        logic [7:0]  tn;
        int nseg;
        int lens[64];
        int tot;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                lk = $urandom_range(0, 3) == 0 ? 32'($urandom) : 32'($urandom_range(0, 5));
                tn = 8'($urandom_range(0, 3));
                nseg = $urandom_range(1, 4);
                tot = 0;
                for (int k = 0; k < nseg; k++) begin
                    lens[k] = $urandom_range(0, 7) == 0 ? $urandom_range(1, N_BYTE)
                                                         : $urandom_range(1, 4);
                    tot += lens[k];
                end
                if ($urandom_range(0, 4) == 0) tot = $urandom;
                send_segment(1'b0, lk, tn, 16'(tot), 6'(nseg - 1), 6'($urandom), lens[0]);
                sent += lens[0];
                for (int k = 1; k < nseg; k++) begin
                    send_segment(1'b1, lk, tn, 16'($urandom), 6'($urandom),
                                 $urandom_range(0, 5) == 0 ? 6'($urandom) : 6'(k),
                                 lens[k]);
                    sent += lens[k];
                end
            end else begin
                send_byte(make_byte(1'($urandom_range(0, 1)), 32'($urandom_range(0, 5)),
                    8'($urandom_range(0, 3)), 16'($urandom), 6'($urandom),
                    6'($urandom), 1'($urandom_range(0, 1))));
                sent++;
            end
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < N_ENT; i++) begin
            slot_valid[i] = 1'b0; slot_link[i] = '0; slot_trans[i] = '0;
            slot_length[i] = '0; slot_total[i] = '0; slot_last[i] = '0;
        end
        pred_pos = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_table_full();
        test_backpressure();
        test_random(1450);
        if (error_count == 0)
            $display("segmented_transaction_reassembly_core verification clean");
        else
            $display("segmented_transaction_reassembly_core verification failed");
        $finish;
    end
endmodule

>>> segmented_transaction_reassembly_core.f
src/str_pkg.sv
src/str_search.sv
src/segmented_transaction_reassembly_core.sv
tb/segmented_transaction_reassembly_core_tb.sv
